### src/hsd_pkg.sv
`timescale 1ns / 1ps

package hsd_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned S_W   = 14;
    localparam int unsigned LV_W  = 9;
    localparam int unsigned IDX_W = 5;
    localparam int unsigned BUS_W = 24;

    localparam logic [CP_W-1:0] S_BASE  = 21'h00AC00;
    localparam logic [CP_W-1:0] S_LIMIT = 21'h00D7A4;
    localparam logic [CP_W-1:0] L_BASE  = 21'h001100;
    localparam logic [CP_W-1:0] V_BASE  = 21'h001161;
    localparam logic [CP_W-1:0] T_BASE  = 21'h0011A7;

    // s / 28 = ((s >> 2) * 4682) >> 15, exact for s < 11172
    localparam logic [12:0] RECIP_7   = 13'd4682;
    localparam int unsigned SHIFT_7   = 15;
    // lv / 21 = (lv * 391) >> 13, exact for lv < 399
    localparam logic [8:0]  RECIP_21  = 9'd391;
    localparam int unsigned SHIFT_21  = 13;

    typedef struct packed {
        logic             hangul;
        logic [CP_W-1:0]  cp;
        logic [S_W-1:0]   s;
        logic [LV_W-1:0]  lv;
        logic [IDX_W-1:0] l;
        logic [IDX_W-1:0] t;
    } t_word;

    typedef enum logic [1:0] {
        PH_L,
        PH_V,
        PH_T
    } t_phase;

endpackage

### src/hsd_front.sv
`timescale 1ns / 1ps

module hsd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [hsd_pkg::CP_W-1:0] i_cp,
    output logic                o_valid,
    input  logic                i_ready,
    output hsd_pkg::t_word      o_word
);
    import hsd_pkg::*;

    logic  r_vld;
    logic  n_vld;
    t_word r_word;
    t_word n_word;
    logic  w_load;

    always_comb begin
        o_ready = !r_vld || i_ready;
        w_load  = i_valid && o_ready;
        n_vld   = w_load ? 1'b1 : (i_ready ? 1'b0 : r_vld);
        n_word        = '0;
        n_word.cp     = i_cp;
        n_word.hangul = (i_cp >= S_BASE) && (i_cp < S_LIMIT);
        n_word.s      = S_W'(i_cp - S_BASE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_vld;
    assign o_word  = r_word;

endmodule

### src/hsd_divide.sv
`timescale 1ns / 1ps

module hsd_divide (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hsd_pkg::t_word i_word,
    output logic           o_valid,
    input  logic           i_ready,
    output hsd_pkg::t_word o_word
);
    import hsd_pkg::*;

    logic             r_vld_a;
    logic             r_vld_b;
    logic             n_vld_a;
    logic             n_vld_b;
    t_word            r_word_a;
    t_word            r_word_b;
    t_word            n_word_a;
    t_word            n_word_b;
    logic             w_rdy_a;
    logic             w_rdy_b;
    logic             w_load_a;
    logic             w_load_b;
    logic [24:0]      w_prod_7;
    logic [17:0]      w_prod_21;
    logic [S_W-1:0]   w_lv28;

    // stage a: syllable index / 28
    always_comb begin
        w_rdy_b  = !r_vld_b || i_ready;
        w_rdy_a  = !r_vld_a || w_rdy_b;
        w_load_a = i_valid && w_rdy_a;
        w_load_b = r_vld_a && w_rdy_b;
        n_vld_a  = w_load_a ? 1'b1 : (w_rdy_b ? 1'b0 : r_vld_a);
        n_vld_b  = w_load_b ? 1'b1 : (i_ready ? 1'b0 : r_vld_b);

        w_prod_7    = 25'(i_word.s[S_W-1:2]) * 25'(RECIP_7);
        n_word_a    = i_word;
        n_word_a.lv = w_prod_7[SHIFT_7 +: LV_W];
    end

    // stage b: trailing index and lv / 21
    always_comb begin
        w_lv28      = S_W'({5'd0, r_word_a.lv} << 5) - S_W'({5'd0, r_word_a.lv} << 2);
        w_prod_21   = 18'(r_word_a.lv) * 18'(RECIP_21);
        n_word_b    = r_word_a;
        n_word_b.t  = IDX_W'(r_word_a.s - w_lv28);
        n_word_b.l  = w_prod_21[SHIFT_21 +: IDX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= n_vld_a;
            r_vld_b <= n_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_a) begin
            r_word_a <= n_word_a;
        end
        if (w_load_b) begin
            r_word_b <= n_word_b;
        end
    end

    assign o_ready = w_rdy_a;
    assign o_valid = r_vld_b;
    assign o_word  = r_word_b;

endmodule

### src/hsd_emit.sv
`timescale 1ns / 1ps

module hsd_emit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  hsd_pkg::t_word           i_word,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [hsd_pkg::CP_W-1:0] o_cp,
    output logic                     o_last
);
    import hsd_pkg::*;

    logic             r_busy;
    logic             n_busy;
    t_phase           r_ph;
    t_phase           n_ph;
    logic             r_hangul;
    logic             r_has_t;
    logic [CP_W-1:0]  r_cp;
    logic [CP_W-1:0]  r_l_cp;
    logic [CP_W-1:0]  r_v_cp;
    logic [CP_W-1:0]  r_t_cp;
    logic             w_final;
    logic             w_load;
    logic [LV_W-1:0]  w_l21;
    logic [IDX_W-1:0] w_v;

    always_comb begin
        w_final = !r_hangul || (r_ph == PH_T) || ((r_ph == PH_V) && !r_has_t);
        o_ready = !r_busy || (i_ready && w_final);
        w_load  = i_valid && o_ready;
        w_l21   = LV_W'({4'd0, i_word.l} << 4) + LV_W'({4'd0, i_word.l} << 2)
                + LV_W'(i_word.l);
        w_v     = IDX_W'(i_word.lv - w_l21);
    end

    // next state
    always_comb begin
        n_busy = r_busy;
        n_ph   = r_ph;
        if (w_load) begin
            n_busy = 1'b1;
            n_ph   = PH_L;
        end else if (r_busy && i_ready) begin
            if (w_final) begin
                n_busy = 1'b0;
            end else begin
                unique case (r_ph)
                    PH_L:    n_ph = PH_V;
                    PH_V:    n_ph = PH_T;
                    default: n_ph = PH_T;
                endcase
            end
        end
    end

    // outputs
    always_comb begin
        o_valid = r_busy;
        o_last  = w_final;
        if (!r_hangul) begin
            o_cp = r_cp;
        end else begin
            unique case (r_ph)
                PH_L:    o_cp = r_l_cp;
                PH_V:    o_cp = r_v_cp;
                default: o_cp = r_t_cp;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= PH_L;
        end else begin
            r_busy <= n_busy;
            r_ph   <= n_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_hangul <= i_word.hangul;
            r_has_t  <= (i_word.t != '0);
            r_cp     <= i_word.cp;
            r_l_cp   <= L_BASE + CP_W'(i_word.l);
            r_v_cp   <= V_BASE + CP_W'(w_v);
            r_t_cp   <= T_BASE + CP_W'(i_word.t);
        end
    end

endmodule

### src/hangul_syllable_decomposer.sv
`timescale 1ns / 1ps
// path: front register, divide stages a and b, then the emit register
// throughput while m_axis_tready is high: one code point per cycle for
// pass-through; a syllable (lv or lvt) holds the output, one jamo per cycle
// reset: synchronous, active low; clears all valid bits and the emit phase

module hangul_syllable_decomposer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [hsd_pkg::BUS_W-1:0] s_axis_tdata,  // [20:0] code_point
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [hsd_pkg::BUS_W-1:0] m_axis_tdata,  // [20:0] out_code_point
    output logic                      m_axis_tlast
);
    import hsd_pkg::*;

    logic            w_f_valid;
    logic            w_f_ready;
    t_word           w_f_word;
    logic            w_d_valid;
    logic            w_d_ready;
    t_word           w_d_word;
    logic [CP_W-1:0] w_out_cp;

    hsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cp    (s_axis_tdata[CP_W-1:0]),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_word  (w_f_word)
    );

    hsd_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_word  (w_f_word),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_word  (w_d_word)
    );

    hsd_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_word  (w_d_word),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_cp    (w_out_cp),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = BUS_W'(w_out_cp);

endmodule

### bench/hsd_checker.sv
`timescale 1ns / 1ps

module hsd_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [hsd_pkg::BUS_W-1:0] s_axis_tdata,  // [20:0] code_point
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [hsd_pkg::BUS_W-1:0] m_axis_tdata,  // [20:0] out_code_point
    input  logic                      m_axis_tlast,
    output int                        o_errors,
    output int                        o_outstanding
);

    import hsd_pkg::CP_W;
    import hsd_pkg::BUS_W;

    localparam int unsigned SYL_FIRST  = 'hAC00;
    localparam int unsigned SYL_COUNT  = 11172;
    localparam int unsigned LEAD_FIRST = 'h1100;
    localparam int unsigned VOW_FIRST  = 'h1161;
    localparam int unsigned TAIL_FIRST = 'h11A7;
    localparam int unsigned VOW_COUNT  = 21;
    localparam int unsigned TAIL_COUNT = 28;
    localparam int          MAX_REPORT = 10;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } jamo_t;

    jamo_t expected_jamo[$];
    int    mismatches = 0;

    assign o_errors      = mismatches;
    assign o_outstanding = expected_jamo.size();

    task automatic queue_decomposition(input logic [CP_W-1:0] cp);
        int unsigned syl;
        int unsigned lv;
        int unsigned tail;
        jamo_t       j;
        begin
            if (cp < SYL_FIRST || cp >= SYL_FIRST + SYL_COUNT) begin
                j.cp   = cp;
                j.last = 1'b1;
                expected_jamo.push_back(j);
            end else begin
                syl  = cp - SYL_FIRST;
                lv   = syl / TAIL_COUNT;
                tail = syl % TAIL_COUNT;
                j.cp   = CP_W'(LEAD_FIRST + lv / VOW_COUNT);
                j.last = 1'b0;
                expected_jamo.push_back(j);
                j.cp   = CP_W'(VOW_FIRST + lv % VOW_COUNT);
                j.last = (tail == 0);
                expected_jamo.push_back(j);
                if (tail != 0) begin
                    j.cp   = CP_W'(TAIL_FIRST + tail);
                    j.last = 1'b1;
                    expected_jamo.push_back(j);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        jamo_t want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                queue_decomposition(s_axis_tdata[CP_W-1:0]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_jamo.size() == 0) begin
                    if (mismatches < MAX_REPORT) begin
                        $display("%0t: unexpected output transfer cp=%h last=%b",
                                 $realtime, m_axis_tdata, m_axis_tlast);
                    end
                    mismatches++;
                end else begin
                    want = expected_jamo.pop_front();
                    if (m_axis_tdata !== BUS_W'(want.cp) || m_axis_tlast !== want.last) begin
                        if (mismatches < MAX_REPORT) begin
                            $display("%0t: mismatch cp exp=%h got=%h last exp=%b got=%b",
                                     $realtime, BUS_W'(want.cp), m_axis_tdata,
                                     want.last, m_axis_tlast);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

### bench/hangul_syllable_decomposer_tb.sv
`timescale 1ns / 1ps

module hangul_syllable_decomposer_tb;

    import hsd_pkg::CP_W;
    import hsd_pkg::BUS_W;

    localparam int PER_PHASE = 20;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [BUS_W-1:0] s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [BUS_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;

    int errors;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    hangul_syllable_decomposer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    hsd_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_cp(input logic [CP_W-1:0] cp);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= BUS_W'(cp);
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    function automatic logic [CP_W-1:0] random_cp();
        int unsigned pick;
        begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                random_cp = CP_W'($urandom_range('hD7A3, 'hAC00));
            end else if (pick < 62) begin
                // syllable without a trailing jamo
                random_cp = CP_W'('hAC00 + 28 * $urandom_range(398, 0));
            end else if (pick < 72) begin
                random_cp = CP_W'($urandom_range('hAC10, 'hABF0));
            end else if (pick < 80) begin
                random_cp = CP_W'($urandom_range('hD7B0, 'hD790));
            end else begin
                random_cp = CP_W'($urandom);
            end
        end
    endfunction

    logic [CP_W-1:0] directed_cp[] = '{
        21'h000000, 21'h1FFFFF, 21'h00ABFF, 21'h00AC00, 21'h00AC01,
        21'h00AC1B, 21'h00AC1C, 21'h00D7A3, 21'h00D7A4, 21'h00D788,
        21'h00D800, 21'h00DFFF, 21'h00FFFE, 21'h00FFFF, 21'h10FFFF,
        21'h110000, 21'h001100, 21'h0011A7, 21'h155555, 21'h0AAAAA,
        21'h00C544
    };

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_cp[k]) send_cp(directed_cp[k]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int n = 0; n < PER_PHASE; n++) send_cp(random_cp());
        end
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #300000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
